// ===== src/afd_pkg.sv =====
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants for the escaped api frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package afd_pkg;

  localparam logic [7:0] DELIM   = 8'h7E;
  localparam logic [7:0] ESC     = 8'h7D;
  localparam logic [7:0] ESC_XOR = 8'h20;
  localparam logic [7:0] CK_BASE = 8'hFF;

  localparam logic [1:0] MODE_PLAIN = 2'd1;
  localparam logic [1:0] MODE_ESC   = 2'd2;

  localparam logic [1:0] STATUS_GOOD  = 2'd0;
  localparam logic [1:0] STATUS_BADCK = 2'd1;
  localparam logic [1:0] STATUS_ABORT = 2'd2;
  localparam logic [1:0] STATUS_EMPTY = 2'd3;

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_LEN_HI = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_CHECK  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_word_t;

endpackage

`default_nettype wire

// ===== src/afd_fsm.sv =====
// ----------------------------------------------------------------------------
// afd_fsm
// Byte state machine: delimiter hunt, length, data with one-word hold, checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module afd_fsm (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wen,
  input  wire logic [1:0]        cfg_wdata,
  input  wire logic              byte_accept,
  input  wire logic [7:0]        rx_byte,
  output afd_pkg::res_word_t     res_word
);
  import afd_pkg::*;

  logic [1:0]  api_mode_r;
  phase_t      phase_r, phase_nxt;
  logic        esc_pending_r, esc_pending_nxt;
  logic [15:0] frame_length_r, frame_length_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_valid_r, held_valid_nxt;

  logic        esc_mode;
  logic        esc_eff;
  logic [7:0]  v;
  logic [15:0] left_dec;
  logic [15:0] len_full;

  assign esc_mode = (api_mode_r == MODE_ESC);
  assign esc_eff  = esc_mode & esc_pending_r;
  assign v        = esc_eff ? (rx_byte ^ ESC_XOR) : rx_byte;
  assign left_dec = bytes_left_r - 16'd1;
  assign len_full = {frame_length_r[15:8], v};

  always_comb begin
    phase_nxt        = phase_r;
    esc_pending_nxt  = esc_pending_r;
    frame_length_nxt = frame_length_r;
    bytes_left_nxt   = bytes_left_r;
    running_sum_nxt  = running_sum_r;
    held_byte_nxt    = held_byte_r;
    held_valid_nxt   = held_valid_r;
    res_word         = '0;
    if (byte_accept) begin
      esc_pending_nxt = esc_eff;
      if (esc_mode && rx_byte == DELIM) begin
        if (phase_r != PH_HUNT) begin
          res_word.valid         = 1'b1;
          res_word.res.data_byte = held_valid_r ? held_byte_r : 8'd0;
          res_word.res.last      = 1'b1;
          res_word.res.status    = STATUS_ABORT;
        end
        esc_pending_nxt = 1'b0;
        held_valid_nxt  = 1'b0;
        held_byte_nxt   = 8'd0;
        running_sum_nxt = 8'd0;
        phase_nxt       = PH_LEN_HI;
      end else if (phase_r == PH_HUNT) begin
        if (rx_byte == DELIM) begin
          phase_nxt       = PH_LEN_HI;
          running_sum_nxt = 8'd0;
          held_valid_nxt  = 1'b0;
          held_byte_nxt   = 8'd0;
        end
      end else if (esc_mode && !esc_eff && rx_byte == ESC) begin
        esc_pending_nxt = 1'b1;
      end else begin
        esc_pending_nxt = 1'b0;
        case (phase_r)
          PH_LEN_HI: begin
            frame_length_nxt = {v, 8'd0};
            phase_nxt        = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            frame_length_nxt = len_full;
            bytes_left_nxt   = len_full;
            running_sum_nxt  = 8'd0;
            phase_nxt        = (len_full == 16'd0) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            running_sum_nxt = running_sum_r + v;
            if (held_valid_r) begin
              res_word.valid         = 1'b1;
              res_word.res.data_byte = held_byte_r;
              res_word.res.last      = 1'b0;
              res_word.res.status    = STATUS_GOOD;
            end
            held_byte_nxt  = v;
            held_valid_nxt = 1'b1;
            bytes_left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            res_word.valid    = 1'b1;
            res_word.res.last = 1'b1;
            if (frame_length_r == 16'd0 || !held_valid_r) begin
              res_word.res.data_byte = 8'd0;
              res_word.res.status    = STATUS_EMPTY;
            end else begin
              res_word.res.data_byte = held_byte_r;
              res_word.res.status    = ((CK_BASE - running_sum_r) == v) ?
                                       STATUS_GOOD : STATUS_BADCK;
            end
            held_valid_nxt = 1'b0;
            held_byte_nxt  = 8'd0;
            phase_nxt      = PH_HUNT;
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      api_mode_r     <= MODE_PLAIN;
      phase_r        <= PH_HUNT;
      esc_pending_r  <= 1'b0;
      frame_length_r <= 16'd0;
      bytes_left_r   <= 16'd0;
      running_sum_r  <= 8'd0;
      held_byte_r    <= 8'd0;
      held_valid_r   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        api_mode_r <= cfg_wdata;
      end
      phase_r        <= phase_nxt;
      esc_pending_r  <= esc_pending_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_left_r   <= bytes_left_nxt;
      running_sum_r  <= running_sum_nxt;
      held_byte_r    <= held_byte_nxt;
      held_valid_r   <= held_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_held_phase: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> (phase_r == PH_DATA || phase_r == PH_CHECK))
    else $error("held word outside data or checksum phase");

  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (bytes_left_r != 16'd0))
    else $error("data phase with no bytes left");

  a_mid_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_word.valid && !res_word.res.last) |-> (res_word.res.status == STATUS_GOOD))
    else $error("status set on a non-final word");
`endif

endmodule

`default_nettype wire

// ===== src/afd_out_buf.sv =====
// ----------------------------------------------------------------------------
// afd_out_buf
// Output register with a skid stage between the state machine and the stream.
// ----------------------------------------------------------------------------
`default_nettype none

module afd_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  afd_pkg::res_word_t     wr_word,
  output logic                   space,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output afd_pkg::res_t          out_res
);
  import afd_pkg::*;

  logic out_valid_r;
  res_t out_data_r;
  logic skid_valid_r;
  res_t skid_data_r;
  logic pop;

  assign pop        = out_valid_r & out_tready;
  assign space      = ~skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_res    = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop || !out_valid_r) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= wr_word.valid;
        end
      end else if (wr_word.valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : wr_word.res;
    end else if (wr_word.valid) begin
      skid_data_r <= wr_word.res;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word without output word");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_word.valid |-> !skid_valid_r)
    else $error("write into full buffer");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_tready) |=> skid_valid_r && $stable(skid_data_r))
    else $error("skid word lost while stalled");
`endif

endmodule

`default_nettype wire

// ===== src/api_frame_deframer_escaped.sv =====
// ----------------------------------------------------------------------------
// api_frame_deframer_escaped
// Length-prefixed frame deframer with optional 0x7D byte stuffing.
// ----------------------------------------------------------------------------
// output: each result word is registered in the output register, or in the skid register while out_* stalls
// throughput: one input word per cycle while the skid register is empty, set by the byte state machine
// a two-word output buffer keeps input flowing while one result waits
// reset: synchronous active-low rst_n; hunts for delimiter, api_mode = 1
// ----------------------------------------------------------------------------
`default_nettype none

module api_frame_deframer_escaped (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wen,
  input  wire logic [1:0] cfg_wdata,    // api_mode
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,     // [7:0] rx_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,    // [7:0] data_byte
  output logic            out_tlast,
  output logic [1:0]      out_tuser     // [1:0] status
);
  import afd_pkg::*;

  logic      space;
  logic      byte_accept;
  res_word_t res_word;
  res_t      out_res;

  assign in_tready   = space;
  assign byte_accept = in_tvalid & space;

  afd_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .byte_accept (byte_accept),
    .rx_byte     (in_tdata),
    .res_word    (res_word)
  );

  afd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_word    (res_word),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.data_byte;
  assign out_tlast = out_res.last;
  assign out_tuser = out_res.status;

endmodule

`default_nettype wire
